// ----- rtl/e2r_pkg.sv -----
`default_nettype none
package e2r_pkg;

    // Angle handling in degrees * 128.
    localparam int TURN         = 46080;
    localparam int HALF_TURN    = 23040;
    localparam int QUARTER_TURN = 11520;
    localparam int MAX_STAGES   = 24;

    // CORDIC start value for x, 30 fraction bits.
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    // Rotation order codes.
    localparam logic [2:0] ORD_XYZ = 3'd1;
    localparam logic [2:0] ORD_YZX = 3'd2;
    localparam logic [2:0] ORD_ZXY = 3'd3;
    localparam logic [2:0] ORD_XZY = 3'd4;
    localparam logic [2:0] ORD_YXZ = 3'd5;
    localparam logic [2:0] ORD_ZYX = 3'd6;

    // One angle as it travels down the CORDIC chain.
    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [24:0] z;
        logic               neg_cos;
    } t_lane;

    // Data handed from one cell to the next.
    typedef struct packed {
        logic            valid;
        t_lane [2:0]     lane;
    } t_cell_bus;

    // Arctangent of 2^-i in degrees * 65536.
    function automatic logic signed [24:0] atan_deg(input int i);
        logic signed [24:0] v;
        case (i)
            0: v = 25'sd2949120;  1: v = 25'sd1740967;  2: v = 25'sd919879;
            3: v = 25'sd466945;   4: v = 25'sd234379;   5: v = 25'sd117304;
            6: v = 25'sd58666;    7: v = 25'sd29335;    8: v = 25'sd14668;
            9: v = 25'sd7334;     10: v = 25'sd3667;    11: v = 25'sd1833;
            12: v = 25'sd917;     13: v = 25'sd458;     14: v = 25'sd229;
            15: v = 25'sd115;     16: v = 25'sd57;      17: v = 25'sd29;
            18: v = 25'sd14;      19: v = 25'sd7;       20: v = 25'sd4;
            21: v = 25'sd2;       22: v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/e2r_if.sv -----
`default_nettype none
// Request channel carrying three Euler angles.
interface e2r_in_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] angle_x;
    logic signed [16:0] angle_y;
    logic signed [16:0] angle_z;
    modport source (output valid, angle_x, angle_y, angle_z, input ready);
    modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

// Result channel carrying the rotation matrix.
interface e2r_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/e2r_cordic_cell.sv -----
`default_nettype none
module e2r_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire e2r_pkg::t_cell_bus    i_bus,
    output      e2r_pkg::t_cell_bus    o_bus
);

    e2r_pkg::t_cell_bus r_bus;
    e2r_pkg::t_cell_bus n_bus;

    // One micro-rotation on each of the three angles.
    always_comb begin
        logic signed [32:0] xs;
        logic signed [32:0] ys;
        n_bus = i_bus;
        for (int k = 0; k < 3; k++) begin
            xs = i_bus.lane[k].x >>> STAGE;
            ys = i_bus.lane[k].y >>> STAGE;
            if (!i_bus.lane[k].z[24]) begin
                n_bus.lane[k].x = i_bus.lane[k].x - ys;
                n_bus.lane[k].y = i_bus.lane[k].y + xs;
                n_bus.lane[k].z = i_bus.lane[k].z - e2r_pkg::atan_deg(STAGE);
            end else begin
                n_bus.lane[k].x = i_bus.lane[k].x + ys;
                n_bus.lane[k].y = i_bus.lane[k].y - xs;
                n_bus.lane[k].z = i_bus.lane[k].z + e2r_pkg::atan_deg(STAGE);
            end
        end
    end

    // Payload moves on enable; only the valid bit is reset.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bus.lane <= n_bus.lane;
        end
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else if (i_en) begin
            r_bus.valid <= n_bus.valid;
        end
    end

    assign o_bus = r_bus;

endmodule
`default_nettype wire

// ----- rtl/e2r_matrix.sv -----
`default_nettype none
module e2r_matrix (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic [2:0]         i_order,
    input  wire e2r_pkg::t_cell_bus i_bus,
    output      logic               o_valid,
    output      logic [8:0][15:0]   o_m
);

    localparam logic signed [19:0] ONE = 20'sd262144;

    logic               r_s_valid, r_t_valid, r_m_valid, r_o_valid;
    logic signed [19:0] r_sn [3];
    logic signed [19:0] r_cs [3];
    logic signed [19:0] n_sn [3];
    logic signed [19:0] n_cs [3];
    logic signed [41:0] r_t  [3][3];
    logic signed [41:0] n_t  [3][3];
    logic signed [19:0] r_r  [3][3];
    logic signed [19:0] n_r  [3][3];
    logic signed [63:0] r_m  [3][3];
    logic signed [63:0] n_m  [3][3];
    logic [8:0][15:0]   r_o;
    logic [8:0][15:0]   n_o;

    // Round CORDIC outputs to 18 fraction bits, clamp, and fix cosine sign.
    always_comb begin
        logic signed [20:0] ys;
        logic signed [20:0] xs;
        logic signed [19:0] c;
        for (int k = 0; k < 3; k++) begin
            ys = 21'((i_bus.lane[k].y + 33'sd2048) >>> 12);
            xs = 21'((i_bus.lane[k].x + 33'sd2048) >>> 12);
            if (ys > 21'sd262144)       n_sn[k] = ONE;
            else if (ys < -21'sd262144) n_sn[k] = -ONE;
            else                        n_sn[k] = 20'(ys);
            if (xs > 21'sd262144)       c = ONE;
            else if (xs < -21'sd262144) c = -ONE;
            else                        c = 20'(xs);
            n_cs[k] = i_bus.lane[k].neg_cos ? -c : c;
        end
    end

    // Build the elementary rotations and form the first product.
    always_comb begin
        logic signed [19:0] rx [3][3];
        logic signed [19:0] ry [3][3];
        logic signed [19:0] rz [3][3];
        logic signed [19:0] p  [3][3];
        logic signed [19:0] q  [3][3];
        logic signed [41:0] acc;
        rx = '{'{ONE, 20'sd0, 20'sd0}, '{20'sd0, r_cs[0], -r_sn[0]},
               '{20'sd0, r_sn[0], r_cs[0]}};
        ry = '{'{r_cs[1], 20'sd0, r_sn[1]}, '{20'sd0, ONE, 20'sd0},
               '{-r_sn[1], 20'sd0, r_cs[1]}};
        rz = '{'{r_cs[2], -r_sn[2], 20'sd0}, '{r_sn[2], r_cs[2], 20'sd0},
               '{20'sd0, 20'sd0, ONE}};
        case (i_order)
            e2r_pkg::ORD_YZX: begin p = rx; q = rz; n_r = ry; end
            e2r_pkg::ORD_ZXY: begin p = ry; q = rx; n_r = rz; end
            e2r_pkg::ORD_XZY: begin p = ry; q = rz; n_r = rx; end
            e2r_pkg::ORD_YXZ: begin p = rz; q = rx; n_r = ry; end
            e2r_pkg::ORD_ZYX: begin p = rx; q = ry; n_r = rz; end
            default:          begin p = rz; q = ry; n_r = rx; end
        endcase
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc = '0;
                for (int k = 0; k < 3; k++) begin
                    acc = acc + 42'(p[i][k]) * 42'(q[k][j]);
                end
                n_t[i][j] = acc;
            end
        end
    end

    // Second product, exact in units of 2^-54.
    always_comb begin
        logic signed [63:0] acc;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc = '0;
                for (int k = 0; k < 3; k++) begin
                    acc = acc + 64'(r_t[i][k]) * 64'(r_r[k][j]);
                end
                n_m[i][j] = acc;
            end
        end
    end

    // Round half up to Q1.15 and saturate.
    always_comb begin
        logic signed [63:0] v;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                v = (r_m[i][j] + (64'sd1 <<< 38)) >>> 39;
                if (v > 64'sd32767)       n_o[i * 3 + j] = 16'h7FFF;
                else if (v < -64'sd32768) n_o[i * 3 + j] = 16'h8000;
                else                      n_o[i * 3 + j] = v[15:0];
            end
        end
    end

    // Pipeline registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sn <= n_sn;
            r_cs <= n_cs;
            r_t  <= n_t;
            r_r  <= n_r;
            r_m  <= n_m;
            r_o  <= n_o;
        end
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_t_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_s_valid <= i_bus.valid;
            r_t_valid <= r_s_valid;
            r_m_valid <= r_t_valid;
            r_o_valid <= r_m_valid;
        end
    end

    assign o_valid = r_o_valid;
    assign o_m     = r_o;

endmodule
`default_nettype wire

// ----- rtl/euler_to_rotation_matrix.sv -----
`default_nettype none
// Throughput: one request per cycle while results are taken; the CORDIC chain of
// cells and the two matrix product stages are fully pipelined.
// The whole pipeline stalls while the output register holds an untaken result.
// Synchronous active-low reset empties the pipeline and sets the order to xyz.
module euler_to_rotation_matrix #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_wdata,
    e2r_in_if.sink          i_in,
    e2r_out_if.source       o_out
);

    localparam int NSTG = (CORDIC_STAGES > e2r_pkg::MAX_STAGES) ?
                          e2r_pkg::MAX_STAGES : CORDIC_STAGES;

    logic               r_order_valid_dummy;
    logic [2:0]         r_order;
    logic               en;
    logic               out_valid;
    logic [8:0][15:0]   out_m;
    e2r_pkg::t_cell_bus chain [NSTG + 1];

    // Rotation order register; out-of-range writes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= e2r_pkg::ORD_XYZ;
        end else if (i_cfg_we && i_cfg_wdata >= e2r_pkg::ORD_XYZ &&
                     i_cfg_wdata <= e2r_pkg::ORD_ZYX) begin
            r_order <= i_cfg_wdata;
        end
    end

    // Marks that the block has left reset at least once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_valid_dummy <= 1'b0;
        end else begin
            r_order_valid_dummy <= 1'b1;
        end
    end

    // Pipeline advances unless the output register is held.
    assign en         = !out_valid || o_out.ready;
    assign i_in.ready = en;

    // Reduce each angle to one quarter turn and start the CORDIC.
    always_comb begin
        logic signed [16:0] a [3];
        logic signed [18:0] t;
        logic signed [18:0] r;
        logic               nc;
        a[0] = i_in.angle_x;
        a[1] = i_in.angle_y;
        a[2] = i_in.angle_z;
        chain[0].valid = i_in.valid;
        for (int k = 0; k < 3; k++) begin
            t = 19'(a[k]) + 19'sd92160;
            if (t >= 19'sd138240)     r = t - 19'sd138240;
            else if (t >= 19'sd92160) r = t - 19'sd92160;
            else if (t >= 19'sd46080) r = t - 19'sd46080;
            else                      r = t;
            if (r >= 19'sd23040) r = r - 19'sd46080;
            nc = 1'b0;
            if (r > 19'sd11520) begin
                r  = 19'sd23040 - r;
                nc = 1'b1;
            end else if (r < -19'sd11520) begin
                r  = -19'sd23040 - r;
                nc = 1'b1;
            end
            chain[0].lane[k].x       = e2r_pkg::CORDIC_GAIN;
            chain[0].lane[k].y       = '0;
            chain[0].lane[k].z       = 25'(r) <<< 9;
            chain[0].lane[k].neg_cos = nc;
        end
    end

    // Chain of CORDIC cells, one micro-rotation each.
    for (genvar g = 0; g < NSTG; g++) begin : g_cell
        e2r_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_bus  (chain[g]),
            .o_bus  (chain[g + 1])
        );
    end

    // Sine/cosine rounding, matrix products and output register.
    e2r_matrix u_matrix (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_order(r_order),
        .i_bus  (chain[NSTG]),
        .o_valid(out_valid),
        .o_m    (out_m)
    );

    assign o_out.valid = out_valid;
    assign o_out.m00   = out_m[0];
    assign o_out.m01   = out_m[1];
    assign o_out.m02   = out_m[2];
    assign o_out.m10   = out_m[3];
    assign o_out.m11   = out_m[4];
    assign o_out.m12   = out_m[5];
    assign o_out.m20   = out_m[6];
    assign o_out.m21   = out_m[7];
    assign o_out.m22   = out_m[8];

    // The order register only ever holds a defined order once out of reset.
    a_order_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_order_valid_dummy |-> (r_order >= e2r_pkg::ORD_XYZ &&
                                 r_order <= e2r_pkg::ORD_ZYX))
        else $error("rotation order out of range");

    // A held result stops new requests from entering.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("request accepted while result is held");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES = 16;
    localparam int DRAIN_CYCLES = STAGES + 16;

    // A full result matrix, row by row.
    typedef struct packed {
        logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    } t_matrix;

    typedef longint t_mat3 [3][3];

    // Arctangent of 2^-i in degrees * 65536, used by the sine/cosine predictor.
    localparam longint ATAN_TAB [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_wdata;

    e2r_in_if  in_ch ();
    e2r_out_if out_ch ();

    euler_to_rotation_matrix #(.CORDIC_STAGES(STAGES)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    t_matrix    pending_matrices [$];
    logic [2:0] cur_order;
    int         error_count;
    bit         idle_on;
    int         hold_cycles;
    int         stall_left;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

    // Sine and cosine of an angle in degrees * 128, in units of 2^-18.
    function automatic void angle_sin_cos(input logic signed [16:0] ang,
                                          output longint sn, output longint cs);
        longint r, x, y, z, xs, ys;
        bit     flip;
        r = (longint'(ang) + 2 * e2r_pkg::TURN) % e2r_pkg::TURN;
        flip = 1'b0;
        if (r >= e2r_pkg::HALF_TURN) r = r - e2r_pkg::TURN;
        if (r > e2r_pkg::QUARTER_TURN) begin
            r = e2r_pkg::HALF_TURN - r;
            flip = 1'b1;
        end else if (r < -e2r_pkg::QUARTER_TURN) begin
            r = -e2r_pkg::HALF_TURN - r;
            flip = 1'b1;
        end
        x = 652032874;
        y = 0;
        z = r * 512;
        for (int i = 0; i < STAGES && i < e2r_pkg::MAX_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TAB[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TAB[i];
            end
        end
        sn = (y + 2048) >>> 12;
        cs = (x + 2048) >>> 12;
        if (sn > 262144) sn = 262144;
        if (sn < -262144) sn = -262144;
        if (cs > 262144) cs = 262144;
        if (cs < -262144) cs = -262144;
        if (flip) cs = -cs;
    endfunction

    function automatic void mat_mul(input t_mat3 a, input t_mat3 b, output t_mat3 c);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                c[i][j] = 0;
                for (int k = 0; k < 3; k++) c[i][j] += a[i][k] * b[k][j];
            end
    endfunction

    // Rounds an entry in units of 2^-54 to saturated Q1.15.
    function automatic logic signed [15:0] to_q15(input longint v);
        longint r;
        r = (v + (longint'(1) <<< 38)) >>> 39;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    // Rotation matrix for three angles under the current order.
    function automatic t_matrix pose_matrix(input logic signed [16:0] ax,
                                            input logic signed [16:0] ay,
                                            input logic signed [16:0] az,
                                            input logic [2:0] order);
        longint  sx, cx, sy, cy, sz, cz;
        longint  one;
        t_mat3   rx, ry, rz, p, q, r, t, m;
        t_matrix res;
        one = longint'(1) <<< 18;
        angle_sin_cos(ax, sx, cx);
        angle_sin_cos(ay, sy, cy);
        angle_sin_cos(az, sz, cz);
        rx = '{'{one, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
        ry = '{'{cy, 0, sy}, '{0, one, 0}, '{-sy, 0, cy}};
        rz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, one}};
        case (order)
            e2r_pkg::ORD_YZX: begin p = rx; q = rz; r = ry; end
            e2r_pkg::ORD_ZXY: begin p = ry; q = rx; r = rz; end
            e2r_pkg::ORD_XZY: begin p = ry; q = rz; r = rx; end
            e2r_pkg::ORD_YXZ: begin p = rz; q = rx; r = ry; end
            e2r_pkg::ORD_ZYX: begin p = rx; q = ry; r = rz; end
            default:          begin p = rz; q = ry; r = rx; end
        endcase
        mat_mul(p, q, t);
        mat_mul(t, r, m);
        res.m00 = to_q15(m[0][0]); res.m01 = to_q15(m[0][1]); res.m02 = to_q15(m[0][2]);
        res.m10 = to_q15(m[1][0]); res.m11 = to_q15(m[1][1]); res.m12 = to_q15(m[1][2]);
        res.m20 = to_q15(m[2][0]); res.m21 = to_q15(m[2][1]); res.m22 = to_q15(m[2][2]);
        return res;
    endfunction

    // Receiver: random stall bursts, plus a long hold-off when requested.
    initial begin
        out_ch.ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                out_ch.ready = 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready = 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    function automatic void check_entry(input string name, input logic signed [15:0] exp_v,
                                        input logic signed [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Compare each accepted matrix with the oldest expected one.
    always @(posedge i_clk) begin
        t_matrix exp_m;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_matrices.size() == 0) begin
                $error("unexpected matrix received");
                error_count++;
            end else begin
                exp_m = pending_matrices.pop_front();
                check_entry("m00", exp_m.m00, out_ch.m00);
                check_entry("m01", exp_m.m01, out_ch.m01);
                check_entry("m02", exp_m.m02, out_ch.m02);
                check_entry("m10", exp_m.m10, out_ch.m10);
                check_entry("m11", exp_m.m11, out_ch.m11);
                check_entry("m12", exp_m.m12, out_ch.m12);
                check_entry("m20", exp_m.m20, out_ch.m20);
                check_entry("m21", exp_m.m21, out_ch.m21);
                check_entry("m22", exp_m.m22, out_ch.m22);
            end
        end
    end

    // Sends one request; entered and left just after a falling edge.
    task automatic send_pose(input logic signed [16:0] ax, input logic signed [16:0] ay,
                             input logic signed [16:0] az);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.angle_x = ax;
        in_ch.angle_y = ay;
        in_ch.angle_z = az;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_matrices.push_back(pose_matrix(ax, ay, az, cur_order));
        @(negedge i_clk);
    endtask

    // Waits until the pipeline has drained, then writes the order register.
    task automatic write_order(input logic [2:0] val);
        in_ch.valid = 1'b0;
        while (pending_matrices.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (val >= e2r_pkg::ORD_XYZ && val <= e2r_pkg::ORD_ZYX) cur_order = val;
    endtask

    // Random angle: mostly in range, some near quadrant edges, some anywhere in 17 bits.
    function automatic logic signed [16:0] rand_angle();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 12) return 17'($signed($urandom_range(0, 92160)) - 46080);
        if (sel < 15)
            return 17'(($signed($urandom_range(0, 8)) - 4) * 11520
                       + $signed($urandom_range(0, 6)) - 3);
        return 17'($urandom_range(0, 131071));
    endfunction

    // Extremes of the angle range and the quadrant boundaries.
    task automatic test_directed();
        send_pose(0, 0, 0);
        send_pose(46080, 46080, 46080);
        send_pose(-46080, -46080, -46080);
        send_pose(11520, 0, 0);
        send_pose(0, 11520, 0);
        send_pose(0, 0, 11520);
        send_pose(-11520, 11521, -11521);
        send_pose(23040, -23040, 23039);
        send_pose(11519, -11519, 34560);
        send_pose(17'sh0FFFF, 17'sh10000, 17'sh0FFFF);
        send_pose(17'sh10000, 17'sh0FFFF, 17'sh10000);
        send_pose(46081, -46081, 92160 - 65536);
        send_pose(1, -1, 5760);
    endtask

    // Every order, including writes outside 1..6 that must be ignored.
    task automatic test_orders();
        logic [2:0] seq [8] = '{e2r_pkg::ORD_YZX, e2r_pkg::ORD_ZXY, 3'd0,
                               e2r_pkg::ORD_XZY, e2r_pkg::ORD_YXZ, 3'd7,
                               e2r_pkg::ORD_ZYX, e2r_pkg::ORD_XYZ};
        foreach (seq[i]) begin
            write_order(seq[i]);
            send_pose(5760, 2880, -4000);
            send_pose(11520, -11520, 23040);
            repeat (10) send_pose(rand_angle(), rand_angle(), rand_angle());
        end
    endtask

    // Long random runs under changing orders.
    task automatic test_random();
        for (int ph = 0; ph < 6; ph++) begin
            write_order(ph == 0 ? e2r_pkg::ORD_ZYX : 3'($urandom_range(1, 6)));
            repeat (80) send_pose(rand_angle(), rand_angle(), rand_angle());
        end
    endtask

    // Receiver holds off long enough to back the pipeline up into the input.
    task automatic test_backpressure();
        write_order(e2r_pkg::ORD_XZY);
        hold_cycles = 200;
        repeat (60) send_pose(rand_angle(), rand_angle(), rand_angle());
    endtask

    // Back-to-back requests with no idling on either side.
    task automatic test_full_rate();
        write_order(e2r_pkg::ORD_YXZ);
        idle_on = 1'b0;
        repeat (60) send_pose(rand_angle(), rand_angle(), rand_angle());
    endtask

    initial begin
        error_count    = 0;
        idle_on        = 1'b1;
        hold_cycles    = 0;
        cur_order      = e2r_pkg::ORD_XYZ;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        in_ch.valid    = 1'b0;
        in_ch.angle_x  = '0;
        in_ch.angle_y  = '0;
        in_ch.angle_z  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_orders();
        test_random();
        test_backpressure();
        test_full_rate();

        in_ch.valid = 1'b0;
        while (pending_matrices.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/e2r_pkg.sv
rtl/e2r_if.sv
rtl/e2r_cordic_cell.sv
rtl/e2r_matrix.sv
rtl/euler_to_rotation_matrix.sv
tb/testbench.sv
